[src/mfps_pkg.sv]
// Shared constants for the minimum falling path sum block and its checker.
package mfps_pkg;

  // Width of the side-length write data (cfg_wr_data).
  localparam int CFG_W = 7;

  // Side length after reset.
  localparam int SIZE_RESET = 64;

  // Clock edges from the acceptance of a matrix's final beat to its result beat, when no stall intervenes.
  localparam int RESULT_LAT = 2;

endpackage

[src/min_falling_path_sum.sv]
// Top level: streaming minimum falling path sum over an n by n signed matrix.
//
//   Channel  Direction  Beat contents
//   in_      slave      tdata: element (ELEMENT_BITS, signed), zero padded to bytes
//   out_     master     tdata: min_sum (ELEMENT_BITS + log2 MAX_SIDE, signed), padded
//   cfg_     write      cfg_wr_data: side length n, taken when cfg_wr_en is high
//
// One element is accepted per cycle while in_tready is high. Each beat reads two
// row-buffer entries on the accept edge and writes its own path sum when stage 1
// fires, which also registers a finished matrix's result for the output.
// in_tready drops only while a result waits in a full output register. Reset is
// synchronous and clears counters and output; the row buffer needs no clearing pass.
module min_falling_path_sum #(
  parameter int MAX_SIDE     = 64,
  parameter int ELEMENT_BITS = 16,
  localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
  localparam int CNT_W = $clog2(MAX_SIDE + 1),
  localparam int SUM_W = ELEMENT_BITS + IDX_W,
  localparam int IN_W  = ((ELEMENT_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SUM_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_W-1:0]            in_tdata,   // [ELEMENT_BITS-1:0] element
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_W-1:0]           out_tdata,  // [SUM_W-1:0] min_sum
  input  logic                       cfg_wr_en,
  input  logic [mfps_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int CMP_W = (CNT_W > mfps_pkg::CFG_W) ? CNT_W : mfps_pkg::CFG_W;
  localparam int SIDE_RST = (mfps_pkg::SIZE_RESET > MAX_SIDE) ? MAX_SIDE
                                                              : mfps_pkg::SIZE_RESET;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  typedef struct packed {
    logic first_row;
    logic has_left;
    logic has_right;
    logic last_row;
    logic last_elem;
  } s1_flags_t;

  // Side length and position counters.
  logic [CNT_W-1:0] side_r;
  logic [CNT_W-1:0] side_nxt;
  logic [IDX_W-1:0] col_r;
  logic [IDX_W-1:0] row_r;
  logic [IDX_W-1:0] col_nxt;
  logic [IDX_W-1:0] row_nxt;

  // Stage 1: beat whose buffer reads are in flight.
  logic                          s1_valid_r;
  s1_flags_t                     s1_flags_r;
  logic [IDX_W-1:0]              s1_col_r;
  logic signed [ELEMENT_BITS-1:0] s1_elem_r;

  logic signed [SUM_W-1:0] left_r;
  logic signed [SUM_W-1:0] min_r;
  logic                    out_valid_r;
  logic [SUM_W-1:0]        out_sum_r;

  logic [CMP_W-1:0] cfg_ext;
  logic [CNT_W-1:0] col_inc;
  logic [CNT_W-1:0] row_inc;
  logic             last_col;
  logic             last_row;
  logic             accept;
  logic             s1_stall;
  logic             s1_fire;
  s1_flags_t        s0_flags;
  logic [IDX_W-1:0] rd_addr_b;

  logic [SUM_W-1:0]        rd_a;
  logic [SUM_W-1:0]        rd_b;
  logic signed [SUM_W-1:0] above;
  logic signed [SUM_W-1:0] right;
  logic signed [SUM_W-1:0] best;
  logic signed [SUM_W-1:0] elem_ext;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] min_cand;

  // A side of zero acts as one, anything above MAX_SIDE as MAX_SIDE.
  always_comb begin
    cfg_ext = CMP_W'(cfg_wr_data);
    if (cfg_wr_data == '0) begin
      side_nxt = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_SIDE)) begin
      side_nxt = CNT_W'(MAX_SIDE);
    end else begin
      side_nxt = CNT_W'(cfg_ext);
    end
  end

  assign col_inc  = CNT_W'(col_r) + CNT_W'(1);
  assign row_inc  = CNT_W'(row_r) + CNT_W'(1);
  assign last_col = (col_inc == side_r);
  assign last_row = (row_inc == side_r);

  assign s1_stall  = s1_valid_r && s1_flags_r.last_elem && out_valid_r && !out_tready;
  assign s1_fire   = s1_valid_r && !s1_stall;
  assign in_tready = !s1_stall;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    s0_flags.first_row = (row_r == '0);
    s0_flags.has_left  = (col_r != '0);
    s0_flags.has_right = !last_col;
    s0_flags.last_row  = last_row;
    s0_flags.last_elem = last_col && last_row;
    rd_addr_b = last_col ? col_r : IDX_W'(col_inc);
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : IDX_W'(row_inc);
    end else begin
      col_nxt = IDX_W'(col_inc);
      row_nxt = row_r;
    end
  end

  mfps_row_buf #(
    .DEPTH (MAX_SIDE),
    .WIDTH (SUM_W),
    .AW    (IDX_W)
  ) u_row_buf (
    .clk       (clk),
    .wr_en     (s1_fire),
    .wr_addr   (s1_col_r),
    .wr_data   (sum),
    .rd_en     (accept),
    .rd_addr_a (col_r),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Three-way minimum over the row above, then one add; the first row takes the element alone.
  always_comb begin
    above    = rd_a;
    right    = rd_b;
    elem_ext = {{(SUM_W-ELEMENT_BITS){s1_elem_r[ELEMENT_BITS-1]}}, s1_elem_r};
    best     = above;
    if (s1_flags_r.has_left && (left_r < best)) begin
      best = left_r;
    end
    if (s1_flags_r.has_right && (right < best)) begin
      best = right;
    end
    sum      = s1_flags_r.first_row ? elem_ext : (elem_ext + best);
    min_cand = (s1_flags_r.last_row && (sum < min_r)) ? sum : min_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= CNT_W'(SIDE_RST);
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      left_r      <= '0;
      min_r       <= SUM_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        side_r <= side_nxt;
        col_r  <= '0;
        row_r  <= '0;
        left_r <= '0;
        min_r  <= SUM_MAX;
      end else begin
        if (accept) begin
          col_r <= col_nxt;
          row_r <= row_nxt;
        end
        if (s1_fire) begin
          left_r <= s1_flags_r.first_row ? '0 : above;
          min_r  <= s1_flags_r.last_elem ? SUM_MAX : min_cand;
        end
      end

      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_fire && s1_flags_r.last_elem) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r <= s0_flags;
      s1_col_r   <= col_r;
      s1_elem_r  <= in_tdata[ELEMENT_BITS-1:0];
    end
    if (s1_fire && s1_flags_r.last_elem) begin
      out_sum_r <= min_cand;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_sum_r);

endmodule

[src/mfps_row_buf.sv]
// Row buffer of path sums: one write port, two registered read ports with write forwarding.
module mfps_row_buf #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 22,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] q_a_r;
  logic [WIDTH-1:0] q_b_r;
  logic [WIDTH-1:0] last_wr_r;
  logic             fwd_a_r;
  logic             fwd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      last_wr_r    <= wr_data;
    end
    if (rd_en) begin
      q_a_r   <= mem[rd_addr_a];
      q_b_r   <= mem[rd_addr_b];
      // A write landing on the same edge as the read is picked up from last_wr_r.
      fwd_a_r <= wr_en && (wr_addr == rd_addr_a);
      fwd_b_r <= wr_en && (wr_addr == rd_addr_b);
    end
  end

  assign rd_data_a = fwd_a_r ? last_wr_r : q_a_r;
  assign rd_data_b = fwd_b_r ? last_wr_r : q_b_r;

endmodule

[src/mfps_checker.sv]
// Port-level checker for the minimum falling path sum block, bound to the top level.
module mfps_checker #(
  parameter int OUT_W = 24
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A rising result valid always follows an accepted element by a fixed latency.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, mfps_pkg::RESULT_LAT))
    else $error("result without a matching final element");

  // Input backpressure comes only from a blocked result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output is free");

endmodule

bind min_falling_path_sum mfps_checker #(
  .OUT_W (OUT_W)
) u_mfps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/tb.sv]
// Self-checking testbench for the streaming minimum falling path sum block.
module tb;

  localparam int SIDE_MAX   = 64;
  localparam int ELEM_W     = 16;
  localparam int SUM_OUT_W  = 22;
  localparam int IN_BITS    = 16;
  localparam int OUT_BITS   = 24;
  localparam int CFG_BITS   = mfps_pkg::CFG_W;
  localparam int SUM_TOP    = (1 << 22) - 1;
  localparam int HOLD_LONG  = 300;
  localparam int CYCLE_CAP  = 2000000;
  localparam int PRINT_CAP  = 40;

  typedef enum int {FILL_RANDOM, FILL_LOW, FILL_HIGH} fill_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_BITS-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_BITS-1:0] cfg_wr_data = '0;

  // Elements waiting to be sent and path-sum minima waiting to come out.
  logic [ELEM_W-1:0]    elements_pending[$];
  logic [SUM_OUT_W-1:0] min_sums_due[$];

  // Own copy of the block's state.
  int          path_sums[SIDE_MAX];
  int          left_above;
  int          row_at;
  int          col_at;
  int          last_row_low;
  logic [CFG_BITS-1:0] side_reg;

  int  errors = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_taken = 1'b0;
  bit  hold_req = 1'b0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;

  min_falling_path_sum u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int side_of(logic [CFG_BITS-1:0] s);
    if (s == 0) return 1;
    if (s > SIDE_MAX) return SIDE_MAX;
    return int'(s);
  endfunction

  function automatic void restart_matrix();
    left_above = 0;
    row_at = 0;
    col_at = 0;
    last_row_low = SUM_TOP;
  endfunction

  // Advances the path-sum state by one element; a finished matrix queues its minimum.
  function automatic void track_element(logic signed [ELEM_W-1:0] elem);
    int n;
    int col;
    int best;
    int above;
    int sum;
    n = side_of(side_reg);
    col = (col_at >= n) ? n - 1 : col_at;
    if (row_at == 0) begin
      sum = elem;
      left_above = 0;
    end else begin
      above = path_sums[col];
      best = above;
      if (col > 0 && left_above < best) best = left_above;
      if (col + 1 < n && path_sums[col + 1] < best) best = path_sums[col + 1];
      sum = elem + best;
      left_above = above;
    end
    path_sums[col] = sum;
    if (row_at + 1 >= n && sum < last_row_low) last_row_low = sum;
    if (col + 1 < n) begin
      col_at = col + 1;
    end else begin
      col_at = 0;
      if (row_at + 1 < n) begin
        row_at++;
      end else begin
        min_sums_due.push_back(last_row_low[SUM_OUT_W-1:0]);
        restart_matrix();
      end
    end
  endfunction

  function automatic int pick_gap(bit idle_on);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ELEM_W-1:0] draw_element();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [OUT_BITS-1:0] want,
                                 logic [OUT_BITS-1:0] got);
    if (errors < PRINT_CAP)
      $display("mismatch at cycle %0d: %s: expected 0x%06h, got 0x%06h",
               cycles, what, want, got);
    errors++;
  endtask

  task automatic queue_elements(int count, fill_t fill);
    for (int i = 0; i < count; i++) begin
      case (fill)
        FILL_LOW:  elements_pending.push_back(16'h8000);
        FILL_HIGH: elements_pending.push_back(16'h7fff);
        default:   elements_pending.push_back(draw_element());
      endcase
    end
  endtask

  // Sender pause: everything sent, every minimum received, pipeline drained.
  task automatic wait_idle();
    while (elements_pending.size() != 0 || in_tvalid) @(posedge clk);
    while (min_sums_due.size() != 0) @(posedge clk);
    repeat (mfps_pkg::RESULT_LAT + 3) @(posedge clk);
  endtask

  task automatic write_side(logic [CFG_BITS-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    side_reg = value;
    restart_matrix();
  endtask

  // Driver: one beat from the pending queue, then a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      gap_left = 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (elements_pending.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= elements_pending.pop_front();
        gap_left = pick_gap(send_idle);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_LONG;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap(recv_idle);
    end
  end

  // Monitor: checks result beats first, then feeds accepted elements to the predictor.
  always @(posedge clk) begin : monitor
    logic [SUM_OUT_W-1:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (min_sums_due.size() == 0) begin
          report_mismatch("result beat with nothing expected", '0, out_tdata);
        end else begin
          want = min_sums_due.pop_front();
          if (out_tdata[SUM_OUT_W-1:0] !== want)
            report_mismatch("min_sum", {2'b00, want}, out_tdata);
          if (out_tdata[OUT_BITS-1:SUM_OUT_W] !== '0)
            report_mismatch("tdata padding", {2'b00, want}, out_tdata);
        end
      end
      if (in_tvalid && in_tready) track_element(in_tdata[ELEM_W-1:0]);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int random_items;
    int pick;
    int n;
    int cnt;
    int mats;
    logic [CFG_BITS-1:0] side;
    random_items = 0;
    for (int i = 0; i < SIDE_MAX; i++) path_sums[i] = 0;
    side_reg = CFG_BITS'(mfps_pkg::SIZE_RESET);
    restart_matrix();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset side length: one row at the bottom of the range, abandoned by the next write.
    queue_elements(SIDE_MAX, FILL_LOW);

    // Single element matrices: every element is its own result.
    write_side(1);
    elements_pending.push_back(16'h8000);
    elements_pending.push_back(16'h7fff);
    elements_pending.push_back(16'h0000);
    elements_pending.push_back(16'hffff);
    elements_pending.push_back(16'h0001);
    // A side of zero behaves as one.
    write_side(0);
    elements_pending.push_back(16'h5a5a);
    write_side(2);
    queue_elements(4, FILL_LOW);
    queue_elements(4, FILL_HIGH);
    write_side(3);
    queue_elements(9, FILL_RANDOM);
    // Partial matrix, then a register write that abandons it.
    queue_elements(4, FILL_RANDOM);
    // Sides above the maximum clamp; this one is abandoned partway too.
    write_side(65);
    queue_elements(100, FILL_RANDOM);

    // Back-to-back small matrices against a long receiver hold-off.
    write_side(2);
    send_idle <= 1'b0;
    recv_idle <= 1'b0;
    hold_req <= 1'b1;
    queue_elements(80, FILL_RANDOM);

    write_side(127);
    send_idle <= 1'b1;
    recv_idle <= 1'b1;
    queue_elements(2 * SIDE_MAX, FILL_HIGH);

    while (random_items < 220) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) side = 0;
      else if (pick == 1) side = CFG_BITS'($urandom_range(65, 127));
      else if (pick <= 4) side = CFG_BITS'($urandom_range(9, 12));
      else side = CFG_BITS'($urandom_range(1, 8));
      write_side(side);
      send_idle <= ($urandom_range(0, 3) != 0);
      recv_idle <= ($urandom_range(0, 3) != 0);
      n = side_of(side);
      if (n == SIDE_MAX) begin
        cnt = $urandom_range(20, 100);
        queue_elements(cnt, FILL_RANDOM);
        random_items += cnt;
      end else begin
        mats = (n > 8) ? 1 : $urandom_range(1, 3);
        repeat (mats) queue_elements(n * n, FILL_RANDOM);
        random_items += mats * n * n;
        if (n > 1 && $urandom_range(0, 4) == 0) begin
          cnt = $urandom_range(1, n * n - 1);
          queue_elements(cnt, FILL_RANDOM);
          random_items += cnt;
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
src/mfps_pkg.sv
src/mfps_row_buf.sv
src/min_falling_path_sum.sv
src/mfps_checker.sv
tb/tb.sv
